### rtl/core/csma_pkg.sv
package csma_pkg;

  // Field widths
  localparam int OP_W      = 3;
  localparam int KIND_W    = 4;
  localparam int CNT_W     = 8;
  localparam int NODE_W    = 16;
  localparam int SYM_W     = 16;
  localparam int BASE_W    = 5;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  // Frame timing constants
  localparam int BEACON_BITS      = 256;
  localparam int DATA_BITS        = 512;
  localparam int BITS_PER_SYMBOL  = 4;
  localparam int PREAMBLE_SYMBOLS = 12;
  localparam int ACK_SYMBOLS      = 32;

  // Fixed part of the airtime for each frame type
  localparam logic [WORD_W-1:0] AIR_BEACON = WORD_W'(
      (BEACON_BITS + BITS_PER_SYMBOL - 1) / BITS_PER_SYMBOL + PREAMBLE_SYMBOLS);
  localparam logic [WORD_W-1:0] AIR_DATA = WORD_W'(
      (DATA_BITS + BITS_PER_SYMBOL - 1) / BITS_PER_SYMBOL + PREAMBLE_SYMBOLS + ACK_SYMBOLS);

  // Remainder unit runs one bit per cycle over the random word
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(WORD_W);

  // Operation codes
  localparam logic [OP_W-1:0] OP_SEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 3'd1;
  localparam logic [OP_W-1:0] OP_START   = 3'd2;
  localparam logic [OP_W-1:0] OP_DONE    = 3'd3;
  localparam logic [OP_W-1:0] OP_RECEIVE = 3'd4;

  // Result codes
  localparam logic [KIND_W-1:0] RES_ACCEPTED = 4'd0;
  localparam logic [KIND_W-1:0] RES_REFUSED  = 4'd1;
  localparam logic [KIND_W-1:0] RES_RETRY    = 4'd2;
  localparam logic [KIND_W-1:0] RES_START    = 4'd3;
  localparam logic [KIND_W-1:0] RES_DROPPED  = 4'd4;
  localparam logic [KIND_W-1:0] RES_AIRTIME  = 4'd5;
  localparam logic [KIND_W-1:0] RES_DONE     = 4'd6;
  localparam logic [KIND_W-1:0] RES_RECEIVED = 4'd7;
  localparam logic [KIND_W-1:0] RES_IGNORED  = 4'd8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKOF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_BASE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TURNAROUND = 3'd7;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_POWER,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic pow_step;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic draw_init;
    logic draw_retry;
    logic pow_done;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/csma_backoff_controller.sv
// Channel  Dir  Handshake             Payload
// in       in   in_tvalid/in_tready   tuser: operation; tdata: frame_type, recipient,
//                                     channel_free, random_value
// out      out  out_tvalid/out_tready tuser: result_kind; tdata: delay_symbols,
//                                     held_type, dest_node, delivered
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data (always ready)
//
// One item at a time. Items that draw no delay are evaluated and finished; an initial
// draw also runs the 32 bit-serial remainder steps, and a retry runs the power loop
// steps (at most one per backoff, at most 32 since the span saturates), then the 32
// bit-serial remainder steps.
// Reset is synchronous, active low; configuration returns to its defaults.
// A result waits in the output register; the next item is taken while it waits,
// and the block stalls only when a new result finds that register still full.
module csma_backoff_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [csma_pkg::OP_W-1:0]           in_tuser,   // [2:0] operation
  input  logic [csma_pkg::IN_TDATA_W-1:0]     in_tdata,   // [0] frame_type, [16:1] recipient,
                                                          // [17] channel_free,
                                                          // [49:18] random_value
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csma_pkg::CFG_DAT_W-1:0]      cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csma_pkg::KIND_W-1:0]         out_tuser,  // [3:0] result_kind
  output logic [csma_pkg::OUT_TDATA_W-1:0]    out_tdata   // [31:0] delay_symbols,
                                                          // [32] held_type,
                                                          // [48:33] dest_node,
                                                          // [49] delivered
);
  import csma_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  csma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Registers, state and arithmetic
  csma_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/csma_ctrl.sv
module csma_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  csma_pkg::stat_t stat,
  output csma_pkg::cmd_t  cmd
);
  import csma_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat.draw_retry) state_nxt = ST_POWER;
        else if (stat.draw_init) state_nxt = ST_DIVIDE;
        else state_nxt = ST_FINISH;
      end
      ST_POWER: begin
        if (stat.pow_done) state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.div_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_POWER: begin
        cmd.pow_step = !stat.pow_done;
        cmd.div_load = stat.pow_done;
      end
      ST_DIVIDE: begin
        cmd.div_step = !stat.div_done;
      end
      ST_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Every accepted item is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_EVAL)
    else $error("accepted item not evaluated");

  // Evaluation is never repeated back to back
  a_eval_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EVAL |=> state_r != ST_EVAL)
    else $error("evaluation repeated");

  // Remainder unit is not abandoned before it finishes
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIVIDE && !stat.div_done |=> state_r == ST_DIVIDE)
    else $error("division left early");

endmodule

### rtl/core/csma_datapath.sv
module csma_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  csma_pkg::cmd_t                      cmd,
  output csma_pkg::stat_t                     stat,
  input  logic [csma_pkg::OP_W-1:0]           in_tuser,
  input  logic [csma_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csma_pkg::CFG_DAT_W-1:0]      cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [csma_pkg::KIND_W-1:0]         out_tuser,
  output logic [csma_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import csma_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0]  min_free_r;
  logic [CNT_W-1:0]  max_backoffs_r;
  logic [SYM_W-1:0]  init_low_r;
  logic [SYM_W-1:0]  init_high_r;
  logic [SYM_W-1:0]  retry_low_r;
  logic [SYM_W-1:0]  retry_high_r;
  logic [BASE_W-1:0] exp_base_r;
  logic [SYM_W-1:0]  turnaround_r;

  // Frame state
  logic              pending_r, pending_nxt;
  logic              tx_r, tx_nxt;
  logic              ptype_r, ptype_nxt;
  logic [NODE_W-1:0] pdest_r, pdest_nxt;
  logic [CNT_W-1:0]  fc_r, fc_nxt;
  logic [CNT_W-1:0]  bc_r, bc_nxt;

  // Latched input item
  logic [OP_W-1:0]   op_r;
  logic              ftype_r;
  logic [NODE_W-1:0] rdest_r;
  logic              free_r;
  logic [WORD_W-1:0] rnd_r;

  // Staged result
  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic [WORD_W-1:0] res_delay_r, res_delay_nxt;
  logic              res_type_r, res_type_nxt;
  logic [NODE_W-1:0] res_dest_r, res_dest_nxt;
  logic              res_deliv_r, res_deliv_nxt;
  logic              use_draw_r;
  logic [SYM_W-1:0]  add_base_r;
  logic              draw_init;
  logic              draw_retry;

  // Power loop and remainder unit
  logic [WORD_W-1:0]        x_r;
  logic [CNT_W-1:0]         n_r;
  logic [WORD_W:0]          div_d_r;
  logic [WORD_W:0]          rem_r;
  logic [WORD_W-1:0]        dvd_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;
  logic [WORD_W+BASE_W-1:0] prod;
  logic [WORD_W-1:0]        x_step;
  logic [WORD_W+1:0]        trial;
  logic [WORD_W+1:0]        trial_diff;
  logic [WORD_W:0]          rem_step;
  logic [WORD_W:0]          draw_sum;
  logic [WORD_W-1:0]        draw_delay;

  // Output register
  logic                     out_tvalid_r;
  logic [KIND_W-1:0]        out_kind_r;
  logic [WORD_W-1:0]        out_delay_r;
  logic                     out_type_r;
  logic [NODE_W-1:0]        out_dest_r;
  logic                     out_deliv_r;

  // Helpers for the evaluation step
  logic [SYM_W-1:0] init_span;
  logic [SYM_W-1:0] retry_span;
  logic [CNT_W-1:0] bc_inc;
  logic [CNT_W-1:0] fc_smp;

  assign cfg_ready  = 1'b1;
  assign init_span  = init_high_r - init_low_r;
  assign retry_span = (retry_high_r > retry_low_r) ? (retry_high_r - retry_low_r) : '0;
  assign bc_inc     = (bc_r != {CNT_W{1'b1}}) ? (bc_r + CNT_W'(1)) : bc_r;
  assign fc_smp     = free_r ? ((fc_r != '0) ? (fc_r - CNT_W'(1)) : '0) : min_free_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_free_r     <= CNT_W'(1);
      max_backoffs_r <= CNT_W'(8);
      init_low_r     <= SYM_W'(20);
      init_high_r    <= SYM_W'(320);
      retry_low_r    <= SYM_W'(20);
      retry_high_r   <= SYM_W'(160);
      exp_base_r     <= BASE_W'(2);
      turnaround_r   <= SYM_W'(12);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_FREE:   min_free_r     <= cfg_data[CNT_W-1:0];
        REG_MAX_BACKOF: max_backoffs_r <= cfg_data[CNT_W-1:0];
        REG_INIT_LOW:   init_low_r     <= cfg_data;
        REG_INIT_HIGH:  init_high_r    <= cfg_data;
        REG_RETRY_LOW:  retry_low_r    <= cfg_data;
        REG_RETRY_HIGH: retry_high_r   <= cfg_data;
        REG_EXP_BASE:   exp_base_r     <= cfg_data[BASE_W-1:0];
        REG_TURNAROUND: turnaround_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input latch on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      ftype_r <= in_tdata[0];
      rdest_r <= in_tdata[16:1];
      free_r  <= in_tdata[17];
      rnd_r   <= in_tdata[49:18];
    end
  end

  // Evaluation: state update and result selection
  always_comb begin
    pending_nxt   = pending_r;
    tx_nxt        = tx_r;
    ptype_nxt     = ptype_r;
    pdest_nxt     = pdest_r;
    fc_nxt        = fc_r;
    bc_nxt        = bc_r;
    res_kind_nxt  = RES_IGNORED;
    res_delay_nxt = '0;
    res_type_nxt  = 1'b0;
    res_dest_nxt  = '0;
    res_deliv_nxt = 1'b0;
    draw_init     = 1'b0;
    draw_retry    = 1'b0;
    case (op_r)
      OP_SEND: begin
        if (pending_r) begin
          res_kind_nxt = RES_REFUSED;
          res_type_nxt = ptype_r;
          res_dest_nxt = pdest_r;
        end else begin
          pending_nxt   = 1'b1;
          ptype_nxt     = ftype_r;
          pdest_nxt     = rdest_r;
          fc_nxt        = min_free_r;
          bc_nxt        = '0;
          res_kind_nxt  = RES_ACCEPTED;
          res_type_nxt  = ftype_r;
          res_dest_nxt  = rdest_r;
          res_delay_nxt = {{(WORD_W-SYM_W){1'b0}}, init_low_r};
          draw_init     = (init_high_r >= init_low_r);
        end
      end
      OP_SAMPLE: begin
        if (pending_r && !tx_r) begin
          bc_nxt       = bc_inc;
          fc_nxt       = fc_smp;
          res_type_nxt = ptype_r;
          res_dest_nxt = pdest_r;
          if (fc_smp == '0) begin
            tx_nxt        = 1'b1;
            res_kind_nxt  = RES_START;
            res_delay_nxt = {{(WORD_W-SYM_W){1'b0}}, turnaround_r};
          end else if (max_backoffs_r == '0 || bc_inc <= max_backoffs_r) begin
            res_kind_nxt = RES_RETRY;
            draw_retry   = 1'b1;
          end else begin
            pending_nxt  = 1'b0;
            res_kind_nxt = RES_DROPPED;
          end
        end
      end
      OP_START: begin
        if (tx_r) begin
          res_kind_nxt  = RES_AIRTIME;
          res_type_nxt  = ptype_r;
          res_dest_nxt  = pdest_r;
          res_delay_nxt = (ptype_r ? AIR_DATA : AIR_BEACON)
                          + {{(WORD_W-SYM_W){1'b0}}, turnaround_r};
        end
      end
      OP_DONE: begin
        if (tx_r) begin
          res_kind_nxt  = RES_DONE;
          res_type_nxt  = ptype_r;
          res_dest_nxt  = pdest_r;
          res_deliv_nxt = ptype_r;
          pending_nxt   = 1'b0;
          tx_nxt        = 1'b0;
          ptype_nxt     = 1'b0;
        end
      end
      OP_RECEIVE: begin
        if (!tx_r) begin
          res_kind_nxt = RES_RECEIVED;
          res_type_nxt = ftype_r;
        end
      end
      default: ;
    endcase
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      tx_r      <= 1'b0;
      ptype_r   <= 1'b0;
      pdest_r   <= '0;
      fc_r      <= '0;
      bc_r      <= '0;
    end else if (cmd.eval) begin
      pending_r <= pending_nxt;
      tx_r      <= tx_nxt;
      ptype_r   <= ptype_nxt;
      pdest_r   <= pdest_nxt;
      fc_r      <= fc_nxt;
      bc_r      <= bc_nxt;
    end
  end

  // Staged result
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_kind_r  <= res_kind_nxt;
      res_delay_r <= res_delay_nxt;
      res_type_r  <= res_type_nxt;
      res_dest_r  <= res_dest_nxt;
      res_deliv_r <= res_deliv_nxt;
      use_draw_r  <= draw_init || draw_retry;
      add_base_r  <= draw_init ? init_low_r : retry_low_r;
    end
  end

  // One multiply per power step, saturating at 32 bits
  assign prod   = x_r * exp_base_r;
  assign x_step = (|prod[WORD_W+BASE_W-1:WORD_W]) ? {WORD_W{1'b1}} : prod[WORD_W-1:0];

  // Restoring remainder step: one dividend bit per cycle
  assign trial      = {rem_r, dvd_r[WORD_W-1]};
  assign trial_diff = trial - {1'b0, div_d_r};
  assign rem_step   = (trial >= {1'b0, div_d_r}) ? trial_diff[WORD_W:0] : trial[WORD_W:0];

  // Final draw: base plus remainder, saturating
  assign draw_sum   = {{(WORD_W+1-SYM_W){1'b0}}, add_base_r} + rem_r;
  assign draw_delay = draw_sum[WORD_W] ? {WORD_W{1'b1}} : draw_sum[WORD_W-1:0];

  // Loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r       <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.eval) begin
        n_r       <= '0;
        div_cnt_r <= '0;
      end else begin
        if (cmd.pow_step) n_r <= n_r + CNT_W'(1);
        if (cmd.div_load) div_cnt_r <= '0;
        else if (cmd.div_step) div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
    end
  end

  // Power and remainder operands
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      x_r     <= {{(WORD_W-SYM_W){1'b0}}, retry_span};
      div_d_r <= {{(WORD_W+1-SYM_W){1'b0}}, init_span} + (WORD_W+1)'(1);
      rem_r   <= '0;
      dvd_r   <= rnd_r;
    end else if (cmd.pow_step) begin
      x_r <= x_step;
    end else if (cmd.div_load) begin
      div_d_r <= {1'b0, x_r} + (WORD_W+1)'(1);
      rem_r   <= '0;
      dvd_r   <= rnd_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
    end
  end

  // Status toward the controller
  assign stat.draw_init  = draw_init;
  assign stat.draw_retry = draw_retry;
  assign stat.pow_done   = (n_r == bc_r) || (x_r == '0) || (&x_r)
                           || (exp_base_r == BASE_W'(1));
  assign stat.div_done   = (div_cnt_r == DIV_STEPS);
  assign stat.out_free   = !out_tvalid_r || out_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r  <= res_kind_r;
      out_delay_r <= use_draw_r ? draw_delay : res_delay_r;
      out_type_r  <= res_type_r;
      out_dest_r  <= res_dest_r;
      out_deliv_r <= res_deliv_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OUT_TDATA_W-WORD_W-NODE_W-2){1'b0}},
                       out_deliv_r, out_dest_r, out_type_r, out_delay_r};

  // A frame on air is always a held frame
  a_tx_pending: assert property (@(posedge clk) disable iff (!rst_n)
    tx_r |-> pending_r)
    else $error("transmitting without a held frame");

  // Delivered flag only comes with a finished transmission
  a_deliv_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_deliv_r |-> out_kind_r == RES_DONE)
    else $error("delivered set on a non-done result");

  // Finished remainder is below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r == DIV_STEPS |-> rem_r < div_d_r)
    else $error("remainder out of range");

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csma_pkg::*;

  // Opcodes above OP_RECEIVE are unused and must be ignored
  localparam logic [OP_W-1:0] OP_LAST = 3'd7;
  localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTED = 40;

  // One outcome of the controller, as carried by the result stream
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] delay;
    logic              held_type;
    logic [NODE_W-1:0] dest;
    logic              delivered;
  } mac_outcome_t;

  // Tracks the controller state and the outcomes still to arrive
  class backoff_scoreboard;
    // register copies
    logic [CNT_W-1:0]  min_free;
    logic [CNT_W-1:0]  max_backoffs;
    logic [SYM_W-1:0]  init_lo;
    logic [SYM_W-1:0]  init_hi;
    logic [SYM_W-1:0]  retry_lo;
    logic [SYM_W-1:0]  retry_hi;
    logic [BASE_W-1:0] exp_base;
    logic [SYM_W-1:0]  turnaround;
    // frame state
    bit                frame_held;
    bit                on_air;
    logic              held_kind;
    logic [CNT_W-1:0]  free_left;
    logic [CNT_W-1:0]  backoffs;
    logic [NODE_W-1:0] held_dest;

    mac_outcome_t outcomes_due[$];
    int errors;
    int printed;
    int kind_count[16];

    function new();
      min_free = 8'd1;
      max_backoffs = 8'd8;
      init_lo = 16'd20;
      init_hi = 16'd320;
      retry_lo = 16'd20;
      retry_hi = 16'd160;
      exp_base = 5'd2;
      turnaround = 16'd12;
      frame_held = 0;
      on_air = 0;
      held_kind = 0;
      free_left = '0;
      backoffs = '0;
      held_dest = '0;
      errors = 0;
      printed = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_MIN_FREE:   min_free = val[CNT_W-1:0];
        REG_MAX_BACKOF: max_backoffs = val[CNT_W-1:0];
        REG_INIT_LOW:   init_lo = val;
        REG_INIT_HIGH:  init_hi = val;
        REG_RETRY_LOW:  retry_lo = val;
        REG_RETRY_HIGH: retry_hi = val;
        REG_EXP_BASE:   exp_base = val[BASE_W-1:0];
        REG_TURNAROUND: turnaround = val;
        default: ;
      endcase
    endfunction

    // Retry span scaled by base^backoffs, saturating at 32 bits
    function logic [63:0] scaled_span();
      logic [63:0] span;
      int n;
      span = (retry_hi > retry_lo) ? 64'(retry_hi - retry_lo) : 64'd0;
      for (n = 0; n < backoffs && span != 0 && span < WORD_MAX; n++) begin
        span = span * 64'(exp_base);
        if (span > WORD_MAX) span = WORD_MAX;
      end
      return span;
    endfunction

    // Work out the outcome of one accepted request and queue it
    function void note_request(logic [OP_W-1:0] op, logic ftype, logic [NODE_W-1:0] dest,
                               logic chan_free, logic [WORD_W-1:0] rnd);
      mac_outcome_t o;
      logic [63:0] wide;
      o = '0;
      o.kind = RES_IGNORED;
      case (op)
        OP_SEND: begin
          o.held_type = held_kind;
          o.dest = held_dest;
          if (frame_held) begin
            o.kind = RES_REFUSED;
          end else begin
            frame_held = 1;
            held_kind = ftype;
            held_dest = dest;
            free_left = min_free;
            backoffs = '0;
            wide = 64'(init_lo);
            if (init_hi >= init_lo)
              wide = wide + 64'(rnd) % (64'(init_hi) - 64'(init_lo) + 64'd1);
            o.kind = RES_ACCEPTED;
            o.delay = wide[WORD_W-1:0];
            o.held_type = held_kind;
            o.dest = held_dest;
          end
        end
        OP_SAMPLE: begin
          if (frame_held && !on_air) begin
            if (backoffs != 8'hFF) backoffs = backoffs + 8'd1;
            if (chan_free) begin
              if (free_left != 0) free_left = free_left - 8'd1;
            end else begin
              free_left = min_free;
            end
            o.held_type = held_kind;
            o.dest = held_dest;
            if (free_left == 0) begin
              on_air = 1;
              o.kind = RES_START;
              o.delay = 32'(turnaround);
            end else if (max_backoffs == 0 || backoffs <= max_backoffs) begin
              wide = 64'(retry_lo) + 64'(rnd) % (scaled_span() + 64'd1);
              o.kind = RES_RETRY;
              o.delay = (wide > WORD_MAX) ? '1 : wide[WORD_W-1:0];
            end else begin
              frame_held = 0;
              o.kind = RES_DROPPED;
            end
          end
        end
        OP_START: begin
          if (on_air) begin
            wide = held_kind ? 64'(DATA_BITS) : 64'(BEACON_BITS);
            wide = (wide + BITS_PER_SYMBOL - 1) / BITS_PER_SYMBOL;
            wide = wide + PREAMBLE_SYMBOLS + 64'(turnaround);
            if (held_kind) wide = wide + ACK_SYMBOLS;
            o.kind = RES_AIRTIME;
            o.delay = wide[WORD_W-1:0];
            o.held_type = held_kind;
            o.dest = held_dest;
          end
        end
        OP_DONE: begin
          if (on_air) begin
            o.kind = RES_DONE;
            o.held_type = held_kind;
            o.dest = held_dest;
            o.delivered = held_kind;
            frame_held = 0;
            on_air = 0;
            held_kind = 0;
          end
        end
        OP_RECEIVE: begin
          if (!on_air) begin
            o.kind = RES_RECEIVED;
            o.held_type = ftype;
          end
        end
        default: ;
      endcase
      outcomes_due.push_back(o);
    endfunction

    function int outstanding();
      return outcomes_due.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (printed < MAX_PRINTED) begin
        printed++;
        $display("MISMATCH @%0t: %s", $time, msg);
      end
    endtask

    // Compare one result transfer with the oldest outstanding outcome
    task check_outcome(mac_outcome_t got);
      mac_outcome_t want;
      if (outcomes_due.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing outstanding", got.kind));
        return;
      end
      want = outcomes_due.pop_front();
      kind_count[want.kind]++;
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.delay != want.delay)
        report_mismatch($sformatf("delay %0d, want %0d (kind %0d)",
                                  got.delay, want.delay, want.kind));
      if (got.held_type != want.held_type)
        report_mismatch($sformatf("held_type %0d, want %0d (kind %0d)",
                                  got.held_type, want.held_type, want.kind));
      if (got.dest != want.dest)
        report_mismatch($sformatf("dest %h, want %h (kind %0d)",
                                  got.dest, want.dest, want.kind));
      if (got.delivered != want.delivered)
        report_mismatch($sformatf("delivered %0d, want %0d (kind %0d)",
                                  got.delivered, want.delivered, want.kind));
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OP_W-1:0]        in_tuser;    // [2:0] operation
  logic [IN_TDATA_W-1:0]  in_tdata;    // [0] frame_type, [16:1] recipient,
                                       // [17] channel_free, [49:18] random_value
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DAT_W-1:0]   cfg_data;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [KIND_W-1:0]      out_tuser;   // [3:0] result_kind
  logic [OUT_TDATA_W-1:0] out_tdata;   // [31:0] delay_symbols, [32] held_type,
                                       // [48:33] dest_node, [49] delivered

  backoff_scoreboard sb = new();

  bit calm;          // no idling on either side while set
  int sink_gap;      // receiver cycles left before next ready
  int hold_left;     // receiver long hold-off, in cycles
  int frame_free_pct;
  int requests_sent;
  int settings_used;

  csma_backoff_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("Timeout: block stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random stall per result, plus an occasional long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (sink_gap > 0) begin
        out_tready <= 1'b0;
        sink_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_outcome({out_tuser, out_tdata[31:0], out_tdata[32],
                        out_tdata[48:33], out_tdata[49]});
      sink_gap = calm ? 0 : $urandom_range(0, 14);
    end
  end

  // Offer one request after a random gap; note it once transferred
  task automatic send_item(input logic [OP_W-1:0] op, input logic ftype,
                           input logic [NODE_W-1:0] dest, input logic chan_free,
                           input logic [WORD_W-1:0] rnd);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tuser  <= op;
    in_tdata  <= {6'b0, rnd, chan_free, dest, ftype};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, ftype, dest, chan_free, rnd);
    requests_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Reprogram every register once the block has gone quiet
  task automatic apply_setting(input int min_free, input int max_bo, input int ilo,
                               input int ihi, input int rlo, input int rhi,
                               input int base, input int turn);
    idle_input();
    wait_drained();
    repeat (40) @(posedge clk);
    write_reg(REG_MIN_FREE, 16'(min_free));
    write_reg(REG_MAX_BACKOF, 16'(max_bo));
    write_reg(REG_INIT_LOW, 16'(ilo));
    write_reg(REG_INIT_HIGH, 16'(ihi));
    write_reg(REG_RETRY_LOW, 16'(rlo));
    write_reg(REG_RETRY_HIGH, 16'(rhi));
    write_reg(REG_EXP_BASE, 16'(base));
    write_reg(REG_TURNAROUND, 16'(turn));
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [WORD_W-1:0] draw_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'($urandom_range(0, 1023));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] noise_op();
    return OP_W'($urandom_range(0, OP_LAST));
  endfunction

  // Mostly well-formed frame lifecycles steered by the tracked state, with noise
  task automatic run_traffic(input int count);
    int i;
    int pick;
    logic [OP_W-1:0] op;
    logic chan_free;
    for (i = 0; i < count; i++) begin
      calm = (i % 100) >= 80;
      if (i > 0 && i % 250 == 0) begin
        idle_input();
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (sb.on_air)
        op = (pick < 45) ? OP_START : (pick < 80) ? OP_DONE : noise_op();
      else if (sb.frame_held)
        op = (pick < 80) ? OP_SAMPLE : (pick < 85) ? OP_SEND : noise_op();
      else
        op = (pick < 60) ? OP_SEND : (pick < 75) ? OP_RECEIVE : noise_op();
      if (op == OP_SEND && !sb.frame_held)
        case ($urandom_range(0, 3))
          0: frame_free_pct = 30;
          1: frame_free_pct = 60;
          2: frame_free_pct = 95;
          default: frame_free_pct = 100;
        endcase
      chan_free = $urandom_range(0, 99) < frame_free_pct;
      send_item(op, 1'($urandom_range(0, 1)), 16'($urandom), chan_free, draw_word());
    end
    calm = 0;
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 0;
    sink_gap = 0;
    hold_left = 0;
    frame_free_pct = 60;
    requests_sent = 0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass under reset defaults
    send_item(OP_SEND, 1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);   // accepted, data frame
    send_item(OP_SEND, 1'b0, 16'h1234, 1'b0, 32'h0);           // refused, one held
    send_item(OP_SAMPLE, 1'b0, 16'h0, 1'b0, 32'hFFFF_FFFF);    // busy -> retry
    send_item(OP_SAMPLE, 1'b1, 16'hFFFF, 1'b1, 32'h0);         // free -> start
    send_item(OP_SAMPLE, 1'b0, 16'h0, 1'b1, 32'h5);            // ignored on air
    send_item(OP_SEND, 1'b1, 16'h00FF, 1'b1, 32'h7);           // refused on air
    send_item(OP_RECEIVE, 1'b1, 16'hAAAA, 1'b0, 32'h0);        // ignored on air
    for (k = OP_RECEIVE + 1; k <= OP_LAST; k++)
      send_item(OP_W'(k), 1'b1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF); // unused opcodes
    send_item(OP_START, 1'b0, 16'h0, 1'b0, 32'h0);             // data airtime
    send_item(OP_DONE, 1'b0, 16'h0, 1'b0, 32'h0);              // delivered
    send_item(OP_START, 1'b1, 16'h0, 1'b0, 32'h0);             // ignored, idle
    send_item(OP_DONE, 1'b1, 16'h0, 1'b0, 32'h0);              // ignored, idle
    send_item(OP_SAMPLE, 1'b0, 16'h0, 1'b1, 32'h0);            // ignored, no frame
    send_item(OP_RECEIVE, 1'b1, 16'h5555, 1'b1, 32'h0);        // received
    send_item(OP_SEND, 1'b0, 16'h0000, 1'b0, 32'h0);           // beacon accepted
    // busy samples walk the backoff count past the limit, then drop
    for (k = 0; k < 9; k++)
      send_item(OP_SAMPLE, 1'b0, 16'h0, 1'b0, draw_word());
    send_item(OP_RECEIVE, 1'b0, 16'h0, 1'b0, 32'h0);

    // Defaults, starting with a long receiver hold-off so the input backs up
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    run_traffic(250);

    // Unlimited backoffs, wide spans, fast-growing retry span
    apply_setting(255, 0, 0, 65535, 1, 65535, 16, 65535);
    run_traffic(180);

    // Immediate start, inverted ranges, unit base, zero turnaround
    apply_setting(0, 255, 65535, 0, 65535, 0, 1, 0);
    run_traffic(150);

    // Tight limit, fixed initial backoff, zero base
    apply_setting(3, 1, 100, 100, 7, 9, 0, 1);
    run_traffic(150);

    // Largest base, tiny span, longest turnaround
    apply_setting(2, 255, 0, 0, 0, 1, 31, 65535);
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    run_traffic(150);

    // Unit base over the full span: the power loop ends without a step
    apply_setting(255, 255, 20, 20, 0, 65535, 1, 12);
    run_traffic(100);

    for (k = 0; k < 2; k++) begin
      apply_setting($urandom_range(0, 4), $urandom_range(0, 12), 16'($urandom),
                    16'($urandom), $urandom_range(0, 300), $urandom_range(0, 3000),
                    $urandom_range(0, 31), 16'($urandom));
      run_traffic(75);
    end

    idle_input();
    wait_drained();
    repeat (400) @(posedge clk);

    $display("Ran %0d requests over %0d register settings, with long output stalls.",
             requests_sent, settings_used);
    $display("Outcomes: %0d accepted %0d refused %0d retry %0d start %0d dropped %0d airtime %0d done %0d received %0d ignored",
             sb.kind_count[RES_ACCEPTED], sb.kind_count[RES_REFUSED],
             sb.kind_count[RES_RETRY], sb.kind_count[RES_START],
             sb.kind_count[RES_DROPPED], sb.kind_count[RES_AIRTIME],
             sb.kind_count[RES_DONE], sb.kind_count[RES_RECEIVED],
             sb.kind_count[RES_IGNORED]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/csma_pkg.sv
rtl/core/csma_ctrl.sv
rtl/core/csma_datapath.sv
rtl/core/csma_backoff_controller.sv
test/testbench.sv
